FILE: rtl/core/m127_pkg.sv
// Shared types and constants for the modulo 2^127-1 arithmetic unit.
// No dependencies; used by every module in rtl/core.
package m127_pkg;

  // Field element and intermediate widths
  localparam int unsigned FE_W       = 127;
  localparam int unsigned LIMB_W     = 32;
  localparam int unsigned NUM_LIMBS  = 4;
  localparam int unsigned NUM_PP     = NUM_LIMBS * NUM_LIMBS;
  localparam int unsigned NUM_DIAG   = 2 * NUM_LIMBS - 1;
  localparam int unsigned PP_W       = 2 * LIMB_W;
  localparam int unsigned DIAG_W     = PP_W + 2;
  localparam int unsigned PROD_W     = 2 * PP_W * 2;
  localparam int unsigned NUM_STAGES = 6;

  typedef logic [FE_W-1:0]   fe_t;
  typedef logic [FE_W:0]     sum_t;
  typedef logic [LIMB_W-1:0] limb_t;
  typedef logic [PP_W-1:0]   pp_t;
  typedef logic [DIAG_W-1:0] diag_t;
  typedef logic [PROD_W-1:0] prod_t;

  // The modulus, all ones over 127 bits
  localparam fe_t P_VALUE = '1;

  // Operation codes
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2
  } func_t;

  // Per-stage load enables, driven by the top-level flow control
  typedef struct packed {
    logic s6;
    logic s5;
    logic s4;
    logic s3;
    logic s2;
    logic s1;
  } adv_t;

endpackage

FILE: rtl/core/m127_pp.sv
// Stage 1: 32x32 partial products of a*b and the 128-bit add/subtract sum.
// Depends on m127_pkg.
module m127_pp (
  input  logic                 clk,
  input  m127_pkg::adv_t       adv,
  input  logic [1:0]           func,
  input  m127_pkg::fe_t        a,
  input  m127_pkg::fe_t        b,
  output logic [1:0]           func_r,
  output m127_pkg::pp_t        pp_r [m127_pkg::NUM_PP],
  output m127_pkg::sum_t       sum_r
);

  m127_pkg::limb_t x [m127_pkg::NUM_LIMBS];
  m127_pkg::limb_t y [m127_pkg::NUM_LIMBS];
  m127_pkg::pp_t   pp_nxt [m127_pkg::NUM_PP];
  m127_pkg::fe_t   b_sel;
  m127_pkg::sum_t  sum_nxt;

  // Split operands into 32-bit limbs (top limb holds 31 bits)
  always_comb begin
    x[0] = a[31:0];
    x[1] = a[63:32];
    x[2] = a[95:64];
    x[3] = {1'b0, a[126:96]};
    y[0] = b[31:0];
    y[1] = b[63:32];
    y[2] = b[95:64];
    y[3] = {1'b0, b[126:96]};
  end

  // Sixteen independent limb products
  always_comb begin
    for (int i = 0; i < m127_pkg::NUM_LIMBS; i++) begin
      for (int j = 0; j < m127_pkg::NUM_LIMBS; j++) begin
        pp_nxt[i*m127_pkg::NUM_LIMBS + j] = x[i] * y[j];
      end
    end
  end

  // a - b is taken as a + (p - b); p - b is the 127-bit complement
  always_comb begin
    b_sel   = (func == m127_pkg::FUNC_SUB) ? ~b : b;
    sum_nxt = {1'b0, a} + {1'b0, b_sel};
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      func_r <= func;
      pp_r   <= pp_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

FILE: rtl/core/m127_colsum.sv
// Stages 2-4: column sums of the partial products into the 254-bit product.
// Depends on m127_pkg; fed by m127_pp.
module m127_colsum (
  input  logic                 clk,
  input  m127_pkg::adv_t       adv,
  input  logic [1:0]           func,
  input  m127_pkg::pp_t        pp [m127_pkg::NUM_PP],
  input  m127_pkg::sum_t       sum_in,
  output logic [1:0]           func_r,
  output m127_pkg::prod_t      prod_r,
  output m127_pkg::sum_t       sum_r
);

  m127_pkg::diag_t diag_nxt [m127_pkg::NUM_DIAG];
  m127_pkg::diag_t diag_r   [m127_pkg::NUM_DIAG];
  logic [1:0]      func2_r, func3_r;
  m127_pkg::sum_t  sum2_r, sum3_r;
  m127_pkg::prod_t e_lo, e_cy, o_lo, o_cy;
  m127_pkg::prod_t e_nxt, o_nxt, e_r, o_r;
  m127_pkg::prod_t prod_nxt;

  // Stage 2: sum the products of equal weight (diagonal k = i + j)
  always_comb begin
    for (int k = 0; k < m127_pkg::NUM_DIAG; k++) begin
      diag_nxt[k] = '0;
      for (int i = 0; i < m127_pkg::NUM_LIMBS; i++) begin
        if ((k - i >= 0) && (k - i < m127_pkg::NUM_LIMBS)) begin
          diag_nxt[k] = diag_nxt[k] + {2'b00, pp[i*m127_pkg::NUM_LIMBS + k - i]};
        end
      end
    end
  end

  // Stage 3: even and odd diagonals each tile the word; add their 2-bit carries
  always_comb begin
    e_lo = {diag_r[6][63:0], diag_r[4][63:0], diag_r[2][63:0], diag_r[0][63:0]};
    o_lo = {32'd0, diag_r[5][63:0], diag_r[3][63:0], diag_r[1][63:0], 32'd0};
    e_cy = '0;
    e_cy[65:64]   = diag_r[0][65:64];
    e_cy[129:128] = diag_r[2][65:64];
    e_cy[193:192] = diag_r[4][65:64];
    o_cy = '0;
    o_cy[97:96]   = diag_r[1][65:64];
    o_cy[161:160] = diag_r[3][65:64];
    o_cy[225:224] = diag_r[5][65:64];
    e_nxt = e_lo + e_cy;
    o_nxt = o_lo + o_cy;
  end

  // Stage 4: full product
  assign prod_nxt = e_r + o_r;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      diag_r  <= diag_nxt;
      func2_r <= func;
      sum2_r  <= sum_in;
    end
    if (adv.s3) begin
      e_r     <= e_nxt;
      o_r     <= o_nxt;
      func3_r <= func2_r;
      sum3_r  <= sum2_r;
    end
    if (adv.s4) begin
      prod_r  <= prod_nxt;
      func_r  <= func3_r;
      sum_r   <= sum3_r;
    end
  end

endmodule

FILE: rtl/core/m127_reduce.sv
// Stages 5-6: fold bits at 127 and above back in, then final reduction to 0..p-1.
// Depends on m127_pkg; fed by m127_colsum.
module m127_reduce (
  input  logic                 clk,
  input  m127_pkg::adv_t       adv,
  input  logic [1:0]           func,
  input  m127_pkg::prod_t      prod,
  input  m127_pkg::sum_t       sum_in,
  output m127_pkg::fe_t        res_r
);

  m127_pkg::sum_t s_mul;
  m127_pkg::sum_t s_nxt, s_r;
  m127_pkg::sum_t r_fold;
  m127_pkg::fe_t  res_nxt;

  // Stage 5: product fold (2^127 = 1 mod p) and operation select
  always_comb begin
    s_mul = {1'b0, prod[126:0]} + {1'b0, prod[253:127]};
    unique case (func)
      m127_pkg::FUNC_ADD,
      m127_pkg::FUNC_SUB: s_nxt = sum_in;
      m127_pkg::FUNC_MUL: s_nxt = s_mul;
      default:            s_nxt = '0;
    endcase
  end

  // Stage 6: fold bit 127; only 2^127 itself carries again and maps to 1
  always_comb begin
    r_fold = {1'b0, s_r[126:0]} + {{m127_pkg::FE_W{1'b0}}, s_r[127]};
    if (r_fold[127]) begin
      res_nxt = m127_pkg::fe_t'(1);
    end else if (r_fold[126:0] == m127_pkg::P_VALUE) begin
      res_nxt = '0;
    end else begin
      res_nxt = r_fold[126:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      s_r <= s_nxt;
    end
    if (adv.s6) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/core/mersenne_127_modular_alu.sv
// Add / subtract / multiply modulo 2^127-1, six register stages.
// The last stage is the output register; out_valid is the valid bit of that stage.
// Throughput: one request per cycle while in_stall is low; the 32x32 limb multipliers are fully pipelined.
// A stalled output only holds stages that are full; bubbles close up behind it.
// Reset (synchronous, rst_n low) clears all stage valid bits; data registers are not reset.
// Depends on m127_pkg, m127_pp, m127_colsum, m127_reduce.
module mersenne_127_modular_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_a_low,
  input  logic [62:0] in_a_high,
  input  logic [63:0] in_b_low,
  input  logic [62:0] in_b_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_r_low,
  output logic [62:0] out_r_high
);

  logic [m127_pkg::NUM_STAGES-1:0] valid_r, valid_nxt, ready;
  m127_pkg::adv_t   adv;
  logic [1:0]       func1, func4;
  m127_pkg::pp_t    pp [m127_pkg::NUM_PP];
  m127_pkg::sum_t   sum1, sum4;
  m127_pkg::prod_t  prod;
  m127_pkg::fe_t    res;
  logic             in_acc, out_acc;

  // Stage k may load when it is empty or its contents move on
  always_comb begin
    ready[m127_pkg::NUM_STAGES-1] = !valid_r[m127_pkg::NUM_STAGES-1] || !out_stall;
    for (int k = m127_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_nxt[0] = ready[0] ? in_valid : valid_r[0];
    for (int k = 1; k < m127_pkg::NUM_STAGES; k++) begin
      valid_nxt[k] = ready[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign adv = '{s1: ready[0], s2: ready[1], s3: ready[2],
                 s4: ready[3], s5: ready[4], s6: ready[5]};

  assign in_stall   = !ready[0];
  assign out_valid  = valid_r[m127_pkg::NUM_STAGES-1];
  assign out_r_low  = res[63:0];
  assign out_r_high = res[126:64];
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;

  m127_pp u_pp (
    .clk    (clk),
    .adv    (adv),
    .func   (in_func),
    .a      ({in_a_high, in_a_low}),
    .b      ({in_b_high, in_b_low}),
    .func_r (func1),
    .pp_r   (pp),
    .sum_r  (sum1)
  );

  m127_colsum u_colsum (
    .clk    (clk),
    .adv    (adv),
    .func   (func1),
    .pp     (pp),
    .sum_in (sum1),
    .func_r (func4),
    .prod_r (prod),
    .sum_r  (sum4)
  );

  m127_reduce u_reduce (
    .clk    (clk),
    .adv    (adv),
    .func   (func4),
    .prod   (prod),
    .sum_in (sum4),
    .res_r  (res)
  );

  // Occupancy changes only by accepted requests in and results out
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(valid_r) ==
      $past($countones(valid_r)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline occupancy mismatch");

  // Input stalls only when every stage holds a request
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r))
    else $error("input stalled with a bubble in the pipeline");

  // A delivered result is fully reduced and never equals p
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !((&out_r_high) && (&out_r_low)))
    else $error("result not fully reduced");

endmodule
